/* src/ptrs_pkg.sv */
package ptrs_pkg;

    localparam int SLOT_W  = 4;
    localparam int FIELD_W = 24;
    localparam int MASK_W  = 8;
    localparam int ENTRY_W = 2 * FIELD_W;

    // Item kinds carried on tuser
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_CREATE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] period;
        logic [FIELD_W-1:0] start_delay;
        logic               has_callback;
    } req_t;

    typedef struct packed {
        logic              accepted;
        logic [MASK_W-1:0] fired_mask;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

/* src/ptrs_ram.sv */
module ptrs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/ptrs_engine.sv */
module ptrs_engine #(
    parameter int NUM_TASKS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    input  ptrs_pkg::req_t      req,
    output logic                req_ready,
    input  logic                res_ready,
    output logic                res_valid,
    output ptrs_pkg::res_t      res
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_TASKS);
    localparam logic [ptrs_pkg::SLOT_W:0] SLOT_LIMIT = (ptrs_pkg::SLOT_W + 1)'(NUM_TASKS);

    ptrs_pkg::state_t state_reg, state_next;

    logic [NUM_TASKS-1:0]          active_reg, active_next;
    logic [CNT_W-1:0]              issue_cnt_reg, issue_cnt_next;
    logic                          proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]              proc_idx_reg, proc_idx_next;
    logic [ptrs_pkg::MASK_W-1:0]   mask_reg, mask_next;
    logic                          acc_reg, acc_next;

    logic                          rd_en, wr_en;
    logic [IDX_W-1:0]              rd_addr, wr_addr;
    logic [ptrs_pkg::ENTRY_W-1:0]  rd_data, wr_data;

    logic [ptrs_pkg::FIELD_W-1:0]  rd_period, rd_count, new_count;
    logic                          slot_live, fire, issue_done, create_ok;

    // Slot table: {period, countdown} per slot
    ptrs_ram #(
        .WIDTH (ptrs_pkg::ENTRY_W),
        .DEPTH (NUM_TASKS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Countdown update for the slot whose read data is back
    assign rd_period  = rd_data[ptrs_pkg::ENTRY_W-1:ptrs_pkg::FIELD_W];
    assign rd_count   = rd_data[ptrs_pkg::FIELD_W-1:0];
    assign slot_live  = active_reg[proc_idx_reg] && (rd_period != '0);
    assign fire       = slot_live && (rd_count <= ptrs_pkg::FIELD_W'(1));
    assign new_count  = fire ? rd_period : rd_count - ptrs_pkg::FIELD_W'(1);
    assign issue_done = (issue_cnt_reg == LAST_CNT);
    assign create_ok  = req.has_callback && ({1'b0, req.slot} < SLOT_LIMIT);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptrs_pkg::ST_IDLE: begin
                if (req_valid) begin
                    state_next = (req.func == ptrs_pkg::FUNC_CREATE) ?
                                 ptrs_pkg::ST_DONE : ptrs_pkg::ST_WALK;
                end
            end
            ptrs_pkg::ST_WALK: begin
                if (issue_done && proc_vld_reg) begin
                    state_next = ptrs_pkg::ST_DONE;
                end
            end
            ptrs_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = ptrs_pkg::ST_IDLE;
                end
            end
            default: state_next = ptrs_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath: read slot k while writing back slot k-1
    always_comb begin
        req_ready      = 1'b0;
        res_valid      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = issue_cnt_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = proc_idx_reg;
        wr_data        = {rd_period, new_count};
        issue_cnt_next = issue_cnt_reg;
        proc_vld_next  = 1'b0;
        proc_idx_next  = proc_idx_reg;
        active_next    = active_reg;
        mask_next      = mask_reg;
        acc_next       = acc_reg;
        unique case (state_reg)
            ptrs_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    issue_cnt_next = '0;
                    mask_next      = '0;
                    acc_next       = 1'b0;
                    if (req.func == ptrs_pkg::FUNC_CREATE && create_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = req.slot[IDX_W-1:0];
                        wr_data = {req.period,
                                   (req.start_delay != '0) ? req.start_delay : req.period};
                        active_next[req.slot[IDX_W-1:0]] = 1'b1;
                        acc_next = 1'b1;
                    end
                end
            end
            ptrs_pkg::ST_WALK: begin
                if (!issue_done) begin
                    rd_en          = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    proc_vld_next  = 1'b1;
                    proc_idx_next  = issue_cnt_reg[IDX_W-1:0];
                end
                if (proc_vld_reg && slot_live) begin
                    wr_en = 1'b1;
                    // slots past the mask width still count but are not reported
                    for (int b = 0; b < ptrs_pkg::MASK_W; b++) begin
                        if (fire && (5'(proc_idx_reg) == 5'(b))) begin
                            mask_next[b] = 1'b1;
                        end
                    end
                end
            end
            ptrs_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign res.fired_mask = mask_reg;
    assign res.accepted   = acc_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ptrs_pkg::ST_IDLE;
            active_reg   <= '0;
            proc_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            proc_vld_reg <= proc_vld_next;
        end
    end

    // Walk counters and result payload
    always_ff @(posedge aclk) begin
        issue_cnt_reg <= issue_cnt_next;
        proc_idx_reg  <= proc_idx_next;
        mask_reg      <= mask_next;
        acc_reg       <= acc_next;
    end

endmodule

/* src/periodic_task_release_scheduler.sv */
// Channel | Ports                          | Payload
// --------+--------------------------------+---------------------------------------------
// input   | s_tvalid s_tready s_tdata s_tuser | tuser: func; tdata: slot, period, delay, cb
// result  | m_tvalid m_tready m_tdata      | tdata: fired_mask, accepted
//
// A tick holds the block while the walk reads one slot per cycle from the
// single read port of the slot RAM and writes the previous one back.
// A create does one table write, then gives the result.
// Reset clears the active bits, so no RAM clearing pass is needed.
// One result waits in the output register; a stalled result holds the engine
// only when the next result is ready to leave.
module periodic_task_release_scheduler #(
    parameter int NUM_TASKS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // slot[3:0], period[27:4], start_delay[51:28],
                                   // has_callback[52], zero fill
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // fired_mask[7:0], accepted[8], zero fill
);

    localparam logic [ptrs_pkg::MASK_W-1:0] LIVE_MASK =
        (NUM_TASKS >= ptrs_pkg::MASK_W) ? '1 : ptrs_pkg::MASK_W'((1 << NUM_TASKS) - 1);

    ptrs_pkg::req_t req;
    ptrs_pkg::res_t eng_res;
    ptrs_pkg::res_t res_reg;
    logic           eng_res_valid;
    logic           out_free;
    logic           m_tvalid_reg, m_tvalid_next;

    // Unpack the input transfer
    assign req.func         = s_tuser;
    assign req.slot         = s_tdata[3:0];
    assign req.period       = s_tdata[27:4];
    assign req.start_delay  = s_tdata[51:28];
    assign req.has_callback = s_tdata[52];

    ptrs_engine #(
        .NUM_TASKS (NUM_TASKS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (s_tready),
        .res_ready (out_free),
        .res_valid (eng_res_valid),
        .res       (eng_res)
    );

    // Output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_free) begin
            m_tvalid_next = eng_res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && eng_res_valid) begin
            res_reg <= eng_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, res_reg.accepted, res_reg.fired_mask};

    // No release bit for a slot that does not exist
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:0] & ~LIVE_MASK) == '0))
        else $error("fired_mask names a slot beyond NUM_TASKS");

    // A stored create never reports releases
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == '0))
        else $error("create result carries a fired mask");

    // A create transfer has its result ready on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == ptrs_pkg::FUNC_CREATE) |=> eng_res_valid)
        else $error("create result not produced");

    // The engine takes no transfer while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        eng_res_valid |-> !s_tready)
        else $error("input taken while a result is pending");

endmodule
